### src/akw_pkg.sv
package akw_pkg;

  localparam int unsigned MAX_WORDS = 8;
  localparam int unsigned WC_W      = $clog2(MAX_WORDS + 2);
  localparam int unsigned WS_AW     = $clog2(MAX_WORDS);
  localparam int unsigned T_W       = $clog2(MAX_WORDS * 6 + 1);
  localparam int unsigned RK_DEPTH  = 15;
  localparam int unsigned RK_AW     = 4;
  localparam logic [2:0]  LAST_J    = 3'd5;
  localparam logic [7:0]  ICV_BYTE  = 8'ha6;
  localparam logic [63:0] ICV       = {8{ICV_BYTE}};

  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KEY3 = 3'd3;
  localparam logic [2:0] CFG_KLEN = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ICV = 2'd1;
  localparam logic [1:0] ST_LEN = 2'd2;

  localparam logic [1:0] KL_128 = 2'd0;
  localparam logic [1:0] KL_192 = 2'd1;

  typedef struct packed {
    logic               we;
    logic [RK_AW-1:0]   addr;
    logic [127:0]       data;
  } rk_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // code 3 behaves as a 256-bit key
  function automatic logic [3:0] key_nk(input logic [1:0] kl);
    logic [3:0] nk;
    unique case (kl)
      KL_128:  nk = 4'd4;
      KL_192:  nk = 4'd6;
      default: nk = 4'd8;
    endcase
    return nk;
  endfunction

  function automatic logic [3:0] key_rounds(input logic [1:0] kl);
    return key_nk(kl) + 4'd6;
  endfunction

endpackage

### src/akw_key_exp.sv
module akw_key_exp import akw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [255:0] key_i,
  input  logic [1:0]   key_len_i,
  output rk_wr_t       rk_wr_o,
  output logic         done_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  i_q;
  logic [2:0]  pos_q;
  logic [7:0]  rcon_q;
  logic [31:0] win_q [8];
  logic [95:0] buf_q;

  logic [3:0]  nk;
  logic [5:0]  total;
  logic [31:0] kw32;
  logic [31:0] tmp;
  logic [31:0] nw;
  logic [31:0] word;
  logic        from_key;

  assign nk       = key_nk(key_len_i);
  assign total    = 6'({nk, 2'b00}) + 6'd28;
  assign kw32     = key_i[255 - 32 * i_q[2:0] -: 32];
  assign from_key = i_q < 6'(nk);

  always_comb begin
    tmp = win_q[7];
    if (pos_q == 3'd0) begin
      tmp = sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon_q, 24'd0};
    end else if (nk == 4'd8 && pos_q == 3'd4) begin
      tmp = sub_word(win_q[7]);
    end
    nw   = win_q[3'(4'd8 - nk)] ^ tmp;
    word = from_key ? kw32 : nw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      pos_q  <= '0;
      rcon_q <= 8'h01;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        pos_q  <= '0;
        rcon_q <= 8'h01;
      end else if (busy_q) begin
        i_q <= i_q + 6'd1;
        if (!from_key) begin
          pos_q <= (pos_q == 3'(nk - 4'd1)) ? 3'd0 : pos_q + 3'd1;
          if (pos_q == 3'd0) begin
            rcon_q <= xtime(rcon_q);
          end
        end
        if (i_q == total - 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // key window: oldest word at the bottom, newest at the top
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      for (int k = 0; k < 7; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[7] <= word;
      buf_q    <= {buf_q[63:0], word};
    end
  end

  assign rk_wr_o.we   = busy_q && (i_q[1:0] == 2'b11);
  assign rk_wr_o.addr = i_q[5:2];
  assign rk_wr_o.data = {buf_q, word};
  assign done_o       = done_q;

endmodule

### src/akw_inv_round.sv
module akw_inv_round import akw_pkg::*; (
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         mix_i,
  output logic [127:0] state_o
);

  logic [127:0] iss;
  logic [127:0] ak;
  logic [127:0] mixed;

  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] av [4];
    for (int k = 0; k < 16; k++) begin
      iss[127 - 8 * k -: 8] =
        INV_SBOX[state_i[127 - 8 * ((k % 4) + 4 * (((k / 4) - (k % 4) + 4) % 4)) -: 8]];
    end
    ak = iss ^ rkey_i;
    for (int c = 0; c < 4; c++) begin
      for (int b = 0; b < 4; b++) begin
        av[b] = ak[127 - 8 * (4 * c + b) -: 8];
        x2[b] = xtime(av[b]);
        x4[b] = xtime(x2[b]);
        x8[b] = xtime(x4[b]);
      end
      // multiples 14, 11, 13 and 9 from doublings
      a0 = x8[0] ^ x4[0] ^ x2[0];
      a1 = x8[1] ^ x2[1] ^ av[1];
      a2 = x8[2] ^ x4[2] ^ av[2];
      a3 = x8[3] ^ av[3];
      mixed[127 - 32 * c -: 8] = a0 ^ a1 ^ a2 ^ a3;
      a0 = x8[0] ^ av[0];
      a1 = x8[1] ^ x4[1] ^ x2[1];
      a2 = x8[2] ^ x2[2] ^ av[2];
      a3 = x8[3] ^ x4[3] ^ av[3];
      mixed[119 - 32 * c -: 8] = a0 ^ a1 ^ a2 ^ a3;
      a0 = x8[0] ^ x4[0] ^ av[0];
      a1 = x8[1] ^ av[1];
      a2 = x8[2] ^ x4[2] ^ x2[2];
      a3 = x8[3] ^ x2[3] ^ av[3];
      mixed[111 - 32 * c -: 8] = a0 ^ a1 ^ a2 ^ a3;
      a0 = x8[0] ^ x2[0] ^ av[0];
      a1 = x8[1] ^ x4[1] ^ av[1];
      a2 = x8[2] ^ av[2];
      a3 = x8[3] ^ x4[3] ^ x2[3];
      mixed[103 - 32 * c -: 8] = a0 ^ a1 ^ a2 ^ a3;
    end
    state_o = mix_i ? mixed : ak;
  end

endmodule

### src/aes_key_unwrap_unit.sv
// channel   dir  fields (lsb first)                      accepted when
// s_axis    in   tdata: wrapped_word, tlast: is_last     tvalid && tready
// m_axis    out  tdata: plain_word, tlast: last_out,     tvalid && tready
//                tuser: status
// cfg       in   index/data: key words 0..3, key length   cfg_we_i
// a word that is not the last of a run is taken and the input stays ready for the next
// on the last word the key schedule runs first, then each of the 6*n steps
// is one block decryption of nr rounds on the single round unit (nr = 10, 12, 14)
// each result is a store read, then the output register load, which waits for a free output register
// reset clears the word count, flags and handshakes; no clearing pass
// input is held off from the last word until the final result is loaded
module aes_key_unwrap_unit import akw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // wrapped_word
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // plain_word
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_KEXP, S_SREAD, S_SINIT, S_SROUND, S_SWRITE, S_CHECK, S_OREAD, S_OWAIT, S_ERR
  } state_e;

  state_e            state_q;
  logic [255:0]      key_q;
  logic [1:0]        klen_q;
  logic [63:0]       a_q;
  logic [WC_W-1:0]   wc_q;
  logic              ovf_q;
  logic [WC_W-1:0]   n_q;
  logic [WC_W-1:0]   i_q;
  logic [WC_W-1:0]   k_q;
  logic [2:0]        j_q;
  logic [RK_AW-1:0]  rnd_q;
  logic [127:0]      blk_q;
  logic [1:0]        err_q;
  logic              kx_start_q;
  logic              ov_q;
  logic [63:0]       od_q;
  logic              ol_q;
  logic [1:0]        ou_q;

  logic [63:0]       ws_mem [MAX_WORDS];
  logic [63:0]       ws_rd_q;
  logic [127:0]      rk_mem [RK_DEPTH];
  logic [127:0]      rk_rd_q;

  rk_wr_t            kx_wr;
  logic              kx_done;
  logic [127:0]      rnd_out;
  logic [3:0]        nr;
  logic              acc;
  logic              out_free;
  logic [WC_W-1:0]   wc_inc;
  logic [WC_W-1:0]   n_new;
  logic              ovf_new;
  logic [T_W-1:0]    t;
  logic              ws_we;
  logic [WS_AW-1:0]  ws_waddr;
  logic [63:0]       ws_wdata;
  logic [WS_AW-1:0]  ws_raddr;
  logic [RK_AW-1:0]  rk_raddr;

  assign nr       = key_rounds(klen_q);
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign out_free = !ov_q || m_axis_tready;
  assign wc_inc   = (wc_q < WC_W'(MAX_WORDS + 1)) ? wc_q + 1'b1 : wc_q;
  assign n_new    = wc_inc - 1'b1;
  assign ovf_new  = ovf_q || (wc_q >= WC_W'(MAX_WORDS + 1));
  assign t        = T_W'(n_q) * T_W'(j_q) + T_W'(i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      klen_q <= KL_128;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY0: key_q[255:192] <= cfg_data_i;
        CFG_KEY1: key_q[191:128] <= cfg_data_i;
        CFG_KEY2: key_q[127:64]  <= cfg_data_i;
        CFG_KEY3: key_q[63:0]    <= cfg_data_i;
        CFG_KLEN: klen_q         <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  akw_key_exp u_key_exp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (kx_start_q),
    .key_i     (key_q),
    .key_len_i (klen_q),
    .rk_wr_o   (kx_wr),
    .done_o    (kx_done)
  );

  akw_inv_round u_inv_round (
    .state_i (blk_q),
    .rkey_i  (rk_rd_q),
    .mix_i   (rnd_q != '0),
    .state_o (rnd_out)
  );

  always_comb begin
    ws_we    = 1'b0;
    ws_waddr = WS_AW'(i_q - 1'b1);
    ws_wdata = blk_q[63:0];
    if (state_q == S_SWRITE) begin
      ws_we = 1'b1;
    end else if (acc && wc_q != '0 && wc_q <= WC_W'(MAX_WORDS)) begin
      ws_we    = 1'b1;
      ws_waddr = WS_AW'(wc_q - 1'b1);
      ws_wdata = s_axis_tdata;
    end
    ws_raddr = (state_q == S_OREAD || state_q == S_OWAIT) ? WS_AW'(k_q) : WS_AW'(i_q - 1'b1);
    if (state_q == S_SINIT) begin
      rk_raddr = nr - 4'd1;
    end else if (state_q == S_SROUND && rnd_q != '0) begin
      rk_raddr = rnd_q - 4'd1;
    end else begin
      rk_raddr = nr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ws_we) begin
      ws_mem[ws_waddr] <= ws_wdata;
    end
    ws_rd_q <= ws_mem[ws_raddr];
    if (kx_wr.we) begin
      rk_mem[kx_wr.addr] <= kx_wr.data;
    end
    rk_rd_q <= rk_mem[rk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      a_q        <= '0;
      wc_q       <= '0;
      ovf_q      <= 1'b0;
      n_q        <= '0;
      i_q        <= '0;
      k_q        <= '0;
      j_q        <= '0;
      rnd_q      <= '0;
      err_q      <= ST_OK;
      kx_start_q <= 1'b0;
      ov_q       <= 1'b0;
      od_q       <= '0;
      ol_q       <= 1'b0;
      ou_q       <= ST_OK;
    end else begin
      kx_start_q <= 1'b0;
      if (ov_q && m_axis_tready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (wc_q == '0) begin
              a_q <= s_axis_tdata;
            end
            wc_q  <= wc_inc;
            ovf_q <= ovf_new;
            if (s_axis_tlast) begin
              wc_q  <= '0;
              ovf_q <= 1'b0;
              n_q   <= n_new;
              i_q   <= n_new;
              j_q   <= LAST_J;
              if (ovf_new || n_new < WC_W'(2)) begin
                err_q   <= ST_LEN;
                state_q <= S_ERR;
              end else begin
                kx_start_q <= 1'b1;
                state_q    <= S_KEXP;
              end
            end
          end
        end
        S_KEXP: begin
          if (kx_done) begin
            state_q <= S_SREAD;
          end
        end
        S_SREAD: state_q <= S_SINIT;
        S_SINIT: begin
          rnd_q   <= nr - 4'd1;
          state_q <= S_SROUND;
        end
        S_SROUND: begin
          if (rnd_q == '0) begin
            state_q <= S_SWRITE;
          end else begin
            rnd_q <= rnd_q - 4'd1;
          end
        end
        S_SWRITE: begin
          a_q     <= blk_q[127:64];
          state_q <= S_SREAD;
          if (i_q == WC_W'(1)) begin
            i_q <= n_q;
            if (j_q == '0) begin
              state_q <= S_CHECK;
            end else begin
              j_q <= j_q - 3'd1;
            end
          end else begin
            i_q <= i_q - 1'b1;
          end
        end
        S_CHECK: begin
          k_q <= '0;
          if (a_q == ICV) begin
            state_q <= S_OREAD;
          end else begin
            err_q   <= ST_ICV;
            state_q <= S_ERR;
          end
        end
        S_OREAD: state_q <= S_OWAIT;
        S_OWAIT: begin
          if (out_free) begin
            ov_q <= 1'b1;
            od_q <= ws_rd_q;
            ou_q <= ST_OK;
            ol_q <= (k_q == n_q - 1'b1);
            if (k_q == n_q - 1'b1) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_OREAD;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            od_q    <= '0;
            ou_q    <= err_q;
            ol_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SINIT) begin
      blk_q <= {a_q ^ 64'(t), ws_rd_q} ^ rk_rd_q;
    end else if (state_q == S_SROUND) begin
      blk_q <= rnd_out;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = ou_q;

  a_kx_wr_in_kexp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kx_wr.we |-> state_q == S_KEXP) else $error("round key write outside key schedule");
  a_wc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= WC_W'(MAX_WORDS + 1)) else $error("word count beyond limit");
  a_n_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SREAD |-> (n_q >= WC_W'(2) && n_q <= WC_W'(MAX_WORDS)))
    else $error("unwrap started with bad length");
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ou_q != ST_OK) |-> (ol_q && od_q == '0)) else $error("malformed error beat");

endmodule

### tb/akw_checker.sv
`timescale 1ns / 1ps

module akw_checker import akw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic [1:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output int          mismatches_o,
  output int          waiting_o
);

  typedef struct packed {
    logic [63:0] word;
    logic        last;
    logic [1:0]  status;
  } plain_beat_t;

  plain_beat_t plain_q[$];

  logic [63:0] key_reg[4];
  logic [1:0]  klen_reg;
  logic [63:0] icv_reg;
  logic [63:0] word_reg[MAX_WORDS];
  int          word_cnt;
  logic        ovf_reg;
  logic [31:0] sched[60];
  int          nrounds;

  function automatic logic [7:0] gf_dbl(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) r ^= a;
      a = gf_dbl(a);
      b = b >> 1;
    end
    return r;
  endfunction

  function automatic void build_schedule();
    int nk, kl, total;
    logic [31:0] tmp;
    logic [7:0]  rcon;
    kl = (klen_reg > 2) ? 2 : klen_reg;
    nk = 4 + 2 * kl;
    nrounds = nk + 6;
    total = 4 * (nrounds + 1);
    rcon = 8'h01;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      tmp = sched[i-1];
      if (i % nk == 0) begin
        tmp = {tmp[23:0], tmp[31:24]};
        tmp = {SBOX[tmp[31:24]], SBOX[tmp[23:16]], SBOX[tmp[15:8]], SBOX[tmp[7:0]]};
        tmp ^= {rcon, 24'h0};
        rcon = gf_dbl(rcon);
      end else if (nk > 6 && i % nk == 4) begin
        tmp = {SBOX[tmp[31:24]], SBOX[tmp[23:16]], SBOX[tmp[15:8]], SBOX[tmp[7:0]]};
      end
      sched[i] = sched[i-nk] ^ tmp;
    end
  endfunction

  function automatic logic [127:0] inv_cipher(logic [127:0] blk);
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    for (int r = nrounds; r >= 0; r--) begin
      if (r != nrounds) begin
        for (int rw = 0; rw < 4; rw++)
          for (int c = 0; c < 4; c++)
            t[rw+4*c] = INV_SBOX[s[rw+4*((c-rw+4)&3)]];
        s = t;
      end
      for (int i = 0; i < 16; i++) s[i] ^= sched[4*r+i/4][31-8*(i%4) -: 8];
      if (r != nrounds && r != 0) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_mul(a0,14) ^ gf_mul(a1,11) ^ gf_mul(a2,13) ^ gf_mul(a3,9);
          s[4*c+1] = gf_mul(a0,9) ^ gf_mul(a1,14) ^ gf_mul(a2,11) ^ gf_mul(a3,13);
          s[4*c+2] = gf_mul(a0,13) ^ gf_mul(a1,9) ^ gf_mul(a2,14) ^ gf_mul(a3,11);
          s[4*c+3] = gf_mul(a0,11) ^ gf_mul(a1,13) ^ gf_mul(a2,9) ^ gf_mul(a3,14);
        end
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  task automatic take_wrapped(logic [63:0] w, logic lst);
    int n;
    logic [127:0] blk;
    plain_beat_t pb;
    if (word_cnt == 0) icv_reg = w;
    else if (word_cnt - 1 < MAX_WORDS) word_reg[word_cnt-1] = w;
    else ovf_reg = 1'b1;
    if (word_cnt < MAX_WORDS + 1) word_cnt++;
    if (lst) begin
      n = word_cnt - 1;
      word_cnt = 0;
      if (ovf_reg || n < 2) begin
        ovf_reg = 1'b0;
        pb = '{word: 64'h0, last: 1'b1, status: ST_LEN};
        plain_q.push_back(pb);
      end else begin
        build_schedule();
        for (int j = LAST_J; j >= 0; j--)
          for (int i = n; i >= 1; i--) begin
            blk = inv_cipher({icv_reg ^ 64'(n * j + i), word_reg[i-1]});
            icv_reg = blk[127:64];
            word_reg[i-1] = blk[63:0];
          end
        if (icv_reg != ICV) begin
          pb = '{word: 64'h0, last: 1'b1, status: ST_ICV};
          plain_q.push_back(pb);
        end else begin
          for (int k = 0; k < n; k++) begin
            pb = '{word: word_reg[k], last: (k == n - 1), status: ST_OK};
            plain_q.push_back(pb);
          end
        end
      end
    end
  endtask

  initial begin
    mismatches_o = 0;
    waiting_o = 0;
    key_reg = '{default: 64'h0};
    klen_reg = KL_128;
    icv_reg = 0;
    word_cnt = 0;
    ovf_reg = 0;
  end

  always @(posedge clk_i) begin
    plain_beat_t exp_b;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY0: key_reg[0] = cfg_data_i;
          CFG_KEY1: key_reg[1] = cfg_data_i;
          CFG_KEY2: key_reg[2] = cfg_data_i;
          CFG_KEY3: key_reg[3] = cfg_data_i;
          CFG_KLEN: klen_reg = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_wrapped(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (plain_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("unexpected beat: word %h last %b status %0d",
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          exp_b = plain_q.pop_front();
          if (exp_b.word !== m_axis_tdata || exp_b.last !== m_axis_tlast ||
              exp_b.status !== m_axis_tuser) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("mismatch: exp %h/%b/%0d got %h/%b/%0d", exp_b.word, exp_b.last,
                       exp_b.status, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          end
        end
      end
      waiting_o = plain_q.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench import akw_pkg::*;;

  localparam logic [1:0] KL_256 = 2'd2;
  localparam logic [1:0] KL_ALT = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;
  int          mismatches;
  int          waiting;

  logic [63:0] key_reg[4];
  logic [1:0]  klen_reg;
  logic [31:0] sched[60];
  int          nrounds;
  logic [63:0] plain_buf[MAX_WORDS];
  logic [63:0] wrap_buf[MAX_WORDS+1];
  int          beats_sent, good_runs, icv_runs, len_runs, phases;
  logic        calm;
  int          rx_hold;

  aes_key_unwrap_unit i_dut (.*);

  akw_checker i_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .mismatches_o(mismatches), .waiting_o(waiting)
  );

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(15, 60);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) rx_hold <= pick_gap();
    end
  end

  function automatic logic [7:0] gf_dbl(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void build_schedule();
    int nk, kl, total;
    logic [31:0] tmp;
    logic [7:0]  rcon;
    kl = (klen_reg > 2) ? 2 : klen_reg;
    nk = 4 + 2 * kl;
    nrounds = nk + 6;
    total = 4 * (nrounds + 1);
    rcon = 8'h01;
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      tmp = sched[i-1];
      if (i % nk == 0) begin
        tmp = {tmp[23:0], tmp[31:24]};
        tmp = {SBOX[tmp[31:24]], SBOX[tmp[23:16]], SBOX[tmp[15:8]], SBOX[tmp[7:0]]};
        tmp ^= {rcon, 24'h0};
        rcon = gf_dbl(rcon);
      end else if (nk > 6 && i % nk == 4) begin
        tmp = {SBOX[tmp[31:24]], SBOX[tmp[23:16]], SBOX[tmp[15:8]], SBOX[tmp[7:0]]};
      end
      sched[i] = sched[i-nk] ^ tmp;
    end
  endfunction

  function automatic logic [127:0] fwd_cipher(logic [127:0] blk);
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    for (int r = 0; r <= nrounds; r++) begin
      if (r != 0) begin
        for (int rw = 0; rw < 4; rw++)
          for (int c = 0; c < 4; c++)
            t[rw+4*c] = SBOX[s[rw+4*((c+rw)&3)]];
        s = t;
        if (r != nrounds) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            x = a0 ^ a1 ^ a2 ^ a3;
            s[4*c]   = a0 ^ x ^ gf_dbl(a0 ^ a1);
            s[4*c+1] = a1 ^ x ^ gf_dbl(a1 ^ a2);
            s[4*c+2] = a2 ^ x ^ gf_dbl(a2 ^ a3);
            s[4*c+3] = a3 ^ x ^ gf_dbl(a3 ^ a0);
          end
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= sched[4*r+i/4][31-8*(i%4) -: 8];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  task automatic send_beat(logic [63:0] w, logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3, logic [1:0] kl);
    key_reg = '{k0, k1, k2, k3};
    klen_reg = kl;
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= (i == CFG_KLEN) ? {$urandom(), 30'h0, kl} : key_reg[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  // mode 0: random plaintext, 1: all zeros, 2: all ones
  task automatic wrap_run(int n, bit spoil, int mode);
    logic [127:0] blk;
    int idx;
    for (int i = 0; i < n; i++)
      plain_buf[i] = (mode == 1) ? 64'h0 : (mode == 2) ? '1 : {$urandom(), $urandom()};
    build_schedule();
    wrap_buf[0] = ICV;
    for (int i = 0; i < n; i++) wrap_buf[i+1] = plain_buf[i];
    for (int j = 0; j <= LAST_J; j++)
      for (int i = 1; i <= n; i++) begin
        blk = fwd_cipher({wrap_buf[0], wrap_buf[i]});
        wrap_buf[0] = blk[127:64] ^ 64'(n * j + i);
        wrap_buf[i] = blk[63:0];
      end
    if (spoil) begin
      idx = $urandom_range(0, n);
      wrap_buf[idx][$urandom_range(0, 63)] ^= 1'b1;
      icv_runs++;
    end else begin
      good_runs++;
    end
    for (int i = 0; i <= n; i++) send_beat(wrap_buf[i], i == n);
  endtask

  // n words after the integrity word, too few or too many
  task automatic bad_length_run(int n);
    for (int i = 0; i <= n; i++) send_beat({$urandom(), $urandom()}, i == n);
    len_runs++;
  endtask

  initial begin
    int sel;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_KEY0;
    cfg_data_i = '0;
    beats_sent = 0; good_runs = 0; icv_runs = 0; len_runs = 0; phases = 0;
    calm = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_key('0, '0, '0, '0, KL_128);
    wrap_run(2, 0, 1);
    bad_length_run(0);
    bad_length_run(1);
    wait_drained();
    load_key('1, '1, '1, '1, KL_256);
    wrap_run(MAX_WORDS, 0, 2);
    bad_length_run(MAX_WORDS + 1);
    wait_drained();
    load_key({$urandom(), $urandom()}, {$urandom(), $urandom()},
             {$urandom(), $urandom()}, '1, KL_192);
    wrap_run(2, 1, 0);
    wait_drained();

    calm = 1'b0;
    while (beats_sent < 250) begin
      load_key({$urandom(), $urandom()}, {$urandom(), $urandom()},
               {$urandom(), $urandom()}, {$urandom(), $urandom()},
               2'($urandom_range(KL_128, KL_ALT)));
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 6)) begin
        sel = $urandom_range(0, 99);
        if (sel < 84)
          wrap_run(($urandom_range(0, 3) == 0) ? $urandom_range(2, MAX_WORDS)
                                                : $urandom_range(2, 4), 0, 0);
        else if (sel < 92)
          wrap_run($urandom_range(2, 5), 1, 0);
        else if (sel < 96)
          bad_length_run($urandom_range(0, 1));
        else
          bad_length_run($urandom_range(MAX_WORDS + 1, MAX_WORDS + 3));
      end
      wait_drained();
    end

    $display("%0d wrapped beats in %0d key settings, all key lengths", beats_sent, phases);
    $display("runs: %0d unwrapped, %0d integrity errors, %0d length errors",
             good_runs, icv_runs, len_runs);
    if (mismatches == 0 && waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
